>>> sv/utf8vd_pkg.sv
// ----------------------------------------------------------------------------
// utf8vd_pkg: shared types and constants for the UTF-8 validating decoder
// Transaction payloads, decoder state and result status codes.
// ----------------------------------------------------------------------------
package utf8vd_pkg;

	localparam int unsigned CpWidth    = 21;
	localparam int unsigned CountWidth = 16;

	localparam logic [CountWidth-1:0] MaxCodepointsReset = 16'd1024;

	// result status codes
	localparam logic [1:0] ST_CODE   = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_END    = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} in_t;

	typedef struct packed {
		logic [CpWidth-1:0] code_point;
		logic [1:0]         status;
		logic               is_last;
	} out_t;

	typedef struct packed {
		logic [CpWidth-1:0]    accumulator;
		logic [1:0]            bytes_remaining;
		logic [2:0]            sequence_width;
		logic [CountWidth-1:0] decoded_count;
		logic                  rejected_flag;
	} state_t;

endpackage

>>> sv/utf8vd_decode.sv
// ----------------------------------------------------------------------------
// utf8vd_decode: single-byte decode and validation step
// Next message state and optional result for one byte, given current state.
// ----------------------------------------------------------------------------
module utf8vd_decode import utf8vd_pkg::*; (
	input  state_t                state,
	input  in_t                   item,
	input  logic [CountWidth-1:0] max_codepoints,
	output state_t                state_next,
	output logic                  has_result,
	output out_t                  result
);

	function automatic logic cp_is_bad(input logic [CpWidth-1:0] cp, input logic [2:0] width);
		logic overlong;
		logic surrogate;
		logic nonchar;
		logic control;
		logic too_big;
		overlong  = (width == 3'd2 && cp < 21'h80) ||
		            (width == 3'd3 && cp < 21'h800) ||
		            (width == 3'd4 && cp < 21'h10000);
		surrogate = cp inside {[21'hD800:21'hDFFF]};
		too_big   = cp > 21'h10FFFF;
		nonchar   = cp inside {[21'hFDD0:21'hFDEF]} || (cp[15:1] == 15'h7FFF);
		control   = (cp < 21'h20 && cp != 21'h0A) || cp inside {[21'h7F:21'h9F]};
		return overlong || surrogate || too_big || nonchar || control;
	endfunction

	logic [7:0]            b;
	logic                  last;
	logic                  bad_byte;
	logic [CpWidth-1:0]    acc_new;
	logic [1:0]            rem_new;
	logic [2:0]            width_new;
	logic [CountWidth:0]   count_inc;
	logic                  reject;

	assign b    = item.data_byte;
	assign last = item.end_of_message;
	assign count_inc = {1'b0, state.decoded_count} + 1'b1;

	// byte classification and accumulation
	always_comb begin
		bad_byte  = 1'b0;
		acc_new   = state.accumulator;
		rem_new   = state.bytes_remaining;
		width_new = state.sequence_width;
		if (state.bytes_remaining == 2'd0) begin
			if (b inside {[8'h00:8'h7F]}) begin
				acc_new   = {13'd0, b};
				width_new = 3'd1;
			end else if (b inside {[8'hC2:8'hDF]}) begin
				acc_new   = {16'd0, b[4:0]};
				width_new = 3'd2;
				rem_new   = 2'd1;
			end else if (b inside {[8'hE0:8'hEF]}) begin
				acc_new   = {17'd0, b[3:0]};
				width_new = 3'd3;
				rem_new   = 2'd2;
			end else if (b inside {[8'hF0:8'hF4]}) begin
				acc_new   = {18'd0, b[2:0]};
				width_new = 3'd4;
				rem_new   = 2'd3;
			end else begin
				bad_byte = 1'b1;
			end
		end else begin
			if (b[7:6] != 2'b10) begin
				bad_byte = 1'b1;
			end else begin
				acc_new = {state.accumulator[CpWidth-7:0], b[5:0]};
				rem_new = state.bytes_remaining - 2'd1;
			end
		end
	end

	always_comb begin
		state_next = state;
		has_result = 1'b0;
		result     = '{code_point: '0, status: ST_CODE, is_last: last};
		reject     = 1'b0;

		if (state.rejected_flag) begin
			// dropping bytes until the end of the message
			if (last) begin
				state_next = '0;
				has_result = 1'b1;
				result     = '{code_point: '0, status: ST_END, is_last: 1'b1};
			end
		end else if (bad_byte) begin
			reject = 1'b1;
		end else if (rem_new != 2'd0) begin
			if (last) begin
				reject = 1'b1;
			end else begin
				state_next.accumulator     = acc_new;
				state_next.bytes_remaining = rem_new;
				state_next.sequence_width  = width_new;
			end
		end else if (cp_is_bad(acc_new, width_new) ||
		             count_inc > {1'b0, max_codepoints}) begin
			reject = 1'b1;
		end else begin
			has_result = 1'b1;
			result     = '{code_point: acc_new, status: ST_CODE, is_last: last};
			if (last) begin
				state_next = '0;
			end else begin
				state_next.accumulator     = '0;
				state_next.bytes_remaining = 2'd0;
				state_next.sequence_width  = 3'd0;
				state_next.decoded_count   = count_inc[CountWidth-1:0];
			end
		end

		if (reject) begin
			has_result = 1'b1;
			result     = '{code_point: '0, status: ST_REJECT, is_last: last};
			if (last) begin
				state_next = '0;
			end else begin
				state_next.accumulator     = '0;
				state_next.bytes_remaining = 2'd0;
				state_next.sequence_width  = 3'd0;
				state_next.rejected_flag   = 1'b1;
			end
		end
	end

endmodule

>>> sv/utf8_validating_decoder.sv
// ----------------------------------------------------------------------------
// utf8_validating_decoder: strict UTF-8 decoder with message-level validation
// Decodes a byte stream into code points and rejects malformed messages.
// ----------------------------------------------------------------------------
// Path: a byte is taken into the input register, decoded combinationally,
//   and its result is written into the output register that drives out_valid.
// Throughput: one byte per cycle; the input register stalls only when it
//   holds a byte that produces a result while the output register is full
//   and stalled.
// Reset: arst_n clears all message state, both valid bits and sets
//   max_codepoints to 1024.
module utf8_validating_decoder import utf8vd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_t                   in_data,
	// output channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_t                  out_data,
	// configuration
	input  logic                  cfg_wr_en,
	input  logic [CountWidth-1:0] cfg_wr_data
);

	// input register stage
	logic   valid_s1;
	in_t    item_s1;

	// message state and limit register
	state_t                state_q;
	state_t                state_next;
	logic [CountWidth-1:0] max_codepoints_q;

	// result register
	logic   out_valid_q;
	out_t   out_q;

	// decode outputs
	logic   has_result;
	out_t   result;

	logic   out_free;
	logic   advance_s1;
	logic   in_fire;

	utf8vd_decode u_decode (
		.state          (state_q),
		.item           (item_s1),
		.max_codepoints (max_codepoints_q),
		.state_next     (state_next),
		.has_result     (has_result),
		.result         (result)
	);

	// The output register is free when empty or being drained this cycle.
	// A byte that makes no result (mid-sequence or dropped) moves on even
	// while the output transaction is stalled.
	assign out_free   = !out_valid_q || !out_stall;
	assign advance_s1 = valid_s1 && (out_free || !has_result);
	assign in_stall   = valid_s1 && !advance_s1;
	assign in_fire    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= in_data;
		end
	end

	// State only moves when the byte in the input register is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance_s1) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_codepoints_q <= MaxCodepointsReset;
		end else if (cfg_wr_en) begin
			max_codepoints_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && has_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && has_result) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Non-code results never carry a code point.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != ST_CODE |-> out_q.code_point == '0)
		else $error("non-code result carries a code point");

	// A rejected message holds no partial sequence.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.rejected_flag |-> state_q.bytes_remaining == 2'd0 &&
		                          state_q.accumulator == '0)
		else $error("partial sequence kept after rejection");

	// Any result caused by a final byte leaves the message state clear.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && item_s1.end_of_message |=> state_q == '0)
		else $error("message state not cleared after final byte");

	// An end marker is only produced for a message already rejected.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 && has_result && result.status == ST_END |->
		state_q.rejected_flag)
		else $error("end marker without earlier rejection");

endmodule
